FILE: hw/rtl/tflm_pkg.sv
// shared constants for the trilinear field map lookup
// register map, entry store geometry and pipeline control type
package tflm_pkg;

  localparam int unsigned ADDR_W      = 15;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
  localparam int unsigned REG_W       = 32;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_COPIES  = 4;
  localparam int unsigned INV_FRAC    = 24;
  localparam int unsigned POS_FRAC    = 16;

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [2:0] REG_INV_STEP_X = 3'd3;
  localparam logic [2:0] REG_INV_STEP_Y = 3'd4;
  localparam logic [2:0] REG_INV_STEP_Z = 3'd5;

  typedef struct packed {
    logic vld;
    logic qry;
  } stage_ctrl_t;

endpackage

FILE: hw/rtl/tflm_ram.sv
// entry store copy: one write port, two registered read ports
// depends on tflm_pkg for depth and address width
module tflm_ram #(
  parameter int unsigned DW = 72
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [tflm_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [DW-1:0]                 wdata_i,
  input  logic [tflm_pkg::ADDR_W-1:0]   raddr_a_i,
  input  logic [tflm_pkg::ADDR_W-1:0]   raddr_b_i,
  output logic [DW-1:0]                 rdata_a_o,
  output logic [DW-1:0]                 rdata_b_o
);

  logic [DW-1:0] mem [tflm_pkg::STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

FILE: hw/rtl/tflm_lerp.sv
// one linear interpolation lane, rounded to nearest with halves up
// standalone, no package use beyond widths given by parameters
module tflm_lerp #(
  parameter int unsigned FB   = 24,
  parameter int unsigned FRAC = 16
) (
  input  logic signed [FB-1:0] a_i,
  input  logic signed [FB-1:0] b_i,
  input  logic        [FRAC:0] t_i,
  output logic signed [FB-1:0] y_o
);

  localparam int unsigned PW = FB + FRAC + 3;
  localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(ONE >> 1);

  logic [FRAC:0] tc;
  logic signed [PW-1:0] pa, pb, s;

  assign tc = ONE - t_i;
  assign pa = PW'(a_i) * PW'($signed({1'b0, tc}));
  assign pb = PW'(b_i) * PW'($signed({1'b0, t_i}));
  assign s  = pa + pb + HALF;
  assign y_o = s[FRAC +: FB];

endmodule

FILE: hw/rtl/trilinear_field_map_lookup_top.sv
// trilinear field map lookup, top level
// depends on tflm_pkg, tflm_ram and tflm_lerp

// Nine-stage pipeline that takes one item per clock: a load writes one grid
// entry, a query returns one interpolated field vector. Throughput is one item
// per cycle, limited only by output stall, which freezes the whole pipeline.
// Loads write the entry store at the same stage where queries read it, so
// items see each other in acceptance order. The store is held in four copies
// with two read ports each, giving all eight cell corners in a single read;
// the stage-two 32x32 multiply sets the clock.
module trilinear_field_map_lookup_top #(
  parameter int unsigned NX         = 32,
  parameter int unsigned NY         = 32,
  parameter int unsigned NZ         = 32,
  parameter int unsigned FIELD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [tflm_pkg::ADDR_W-1:0]        entry_index_i,
  input  logic signed [FIELD_BITS-1:0]       load_ex_i,
  input  logic signed [FIELD_BITS-1:0]       load_ey_i,
  input  logic signed [FIELD_BITS-1:0]       load_ez_i,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic signed [31:0]                 pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [FIELD_BITS-1:0]       field_x_o,
  output logic signed [FIELD_BITS-1:0]       field_y_o,
  output logic signed [FIELD_BITS-1:0]       field_z_o,
  output logic                               in_range_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tflm_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned AW   = tflm_pkg::ADDR_W;
  localparam int unsigned NA   = tflm_pkg::NUM_AXES;
  localparam int unsigned NC   = tflm_pkg::NUM_COPIES;
  localparam int unsigned FB   = FIELD_BITS;
  localparam int unsigned DW   = 3 * FB;
  localparam int unsigned SH   = tflm_pkg::INV_FRAC + tflm_pkg::POS_FRAC - FRAC_BITS;
  localparam int unsigned NMXY = (NX > NY) ? NX : NY;
  localparam int unsigned NMAX = (NMXY > NZ) ? NMXY : NZ;
  localparam int unsigned CW   = $clog2(NMAX);
  localparam int unsigned NDIM [NA] = '{NX, NY, NZ};
  localparam logic [AW-1:0] XOFF = AW'(NY * NZ);
  localparam logic [AW-1:0] YOFF = AW'(NZ);

  // configuration registers
  logic signed [31:0] origin_q [NA];
  logic        [31:0] inv_q    [NA];
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        origin_q[a] <= '0;
        inv_q[a]    <= 32'h0100_0000;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tflm_pkg::REG_ORIGIN_X:   origin_q[0] <= pwdata;
        tflm_pkg::REG_ORIGIN_Y:   origin_q[1] <= pwdata;
        tflm_pkg::REG_ORIGIN_Z:   origin_q[2] <= pwdata;
        tflm_pkg::REG_INV_STEP_X: inv_q[0]    <= pwdata;
        tflm_pkg::REG_INV_STEP_Y: inv_q[1]    <= pwdata;
        tflm_pkg::REG_INV_STEP_Z: inv_q[2]    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tflm_pkg::REG_ORIGIN_X:   prdata = origin_q[0];
      tflm_pkg::REG_ORIGIN_Y:   prdata = origin_q[1];
      tflm_pkg::REG_ORIGIN_Z:   prdata = origin_q[2];
      tflm_pkg::REG_INV_STEP_X: prdata = inv_q[0];
      tflm_pkg::REG_INV_STEP_Y: prdata = inv_q[1];
      tflm_pkg::REG_INV_STEP_Z: prdata = inv_q[2];
      default:                  prdata = '0;
    endcase
  end

  // global pipeline enable
  logic en;
  tflm_pkg::stage_ctrl_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;
  logic v9_q;

  assign en         = !(v9_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0;
      s5_q <= '0; s6_q <= '0; s7_q <= '0; s8_q <= '0;
      v9_q <= 1'b0;
    end else if (en) begin
      s1_q <= '{vld: in_valid_i, qry: cmd_i};
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
      s5_q <= s4_q;
      s6_q <= s5_q;
      s7_q <= s6_q;
      s8_q <= s7_q;
      v9_q <= s8_q.vld && s8_q.qry;
    end
  end

  // stage 1: offset from origin
  logic signed [32:0] d1_q [NA];
  logic [AW-1:0]      idx1_q, idx2_q, idx3_q, idx4_q, idx5_q;
  logic [DW-1:0]      ld1_q, ld2_q, ld3_q, ld4_q, ld5_q;
  logic signed [31:0] pos [NA];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        d1_q[a] <= 33'(pos[a]) - 33'(origin_q[a]);
      end
      idx1_q <= entry_index_i;
      ld1_q  <= {load_ez_i, load_ey_i, load_ex_i};
      idx2_q <= idx1_q; ld2_q <= ld1_q;
      idx3_q <= idx2_q; ld3_q <= ld2_q;
      idx4_q <= idx3_q; ld4_q <= ld3_q;
      idx5_q <= idx4_q; ld5_q <= ld4_q;
    end
  end

  // stage 2: scale to grid units
  logic [63:0] prod2_q [NA];
  logic        neg2_q  [NA];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        prod2_q[a] <= d1_q[a][32] ? 64'd0 : 64'(d1_q[a][31:0]) * 64'(inv_q[a]);
        neg2_q[a]  <= d1_q[a][32] && (inv_q[a] != 32'd0);
      end
    end
  end

  // stage 3: range check, cell and weight
  logic [63:0]        g     [NA];
  logic [63:0]        cfull [NA];
  logic [CW-1:0]      cix   [NA];
  logic [NA-1:0]      ax_ok;
  logic [CW-1:0]      cell3_q [NA];
  logic [FRAC_BITS:0] t3_q    [NA];
  logic               ok3_q;
  logic [63:0]        tdiff [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      g[a]     = prod2_q[a] >> SH;
      ax_ok[a] = !neg2_q[a] && (g[a] <= (64'(NDIM[a] - 1) << FRAC_BITS));
      cfull[a] = g[a] >> FRAC_BITS;
      cix[a]   = (cfull[a] >= 64'(NDIM[a] - 1)) ? CW'(NDIM[a] - 2) : CW'(cfull[a]);
      tdiff[a] = g[a] - (64'(cix[a]) << FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        cell3_q[a] <= cix[a];
        t3_q[a]    <= tdiff[a][FRAC_BITS:0];
      end
      ok3_q <= &ax_ok;
    end
  end

  // stage 4: flat base index
  logic [31:0]        flat;
  logic [AW-1:0]      base4_q;
  logic [FRAC_BITS:0] t4_q [NA], t5_q [NA], t6_q [NA];
  logic               ok4_q, ok5_q, ok6_q, ok7_q, ok8_q;

  assign flat = (32'(cell3_q[0]) * 32'(NY) + 32'(cell3_q[1])) * 32'(NZ) + 32'(cell3_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      base4_q <= flat[AW-1:0];
      t4_q    <= t3_q;
      ok4_q   <= ok3_q;
      t5_q    <= t4_q;
      ok5_q   <= ok4_q;
      t6_q    <= t5_q;
      ok6_q   <= ok5_q;
    end
  end

  // stage 5: corner addresses, copy j holds corner y + j[0], z + j[1]
  logic [AW-1:0] ra5_q [NC];
  logic [AW-1:0] rb5_q [NC];
  logic [AW-1:0] ra    [NC];

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      ra[j] = base4_q + (j[0] ? YOFF : '0) + (j[1] ? AW'(1) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NC; j++) begin
        ra5_q[j] <= ra[j];
        rb5_q[j] <= ra[j] + XOFF;
      end
    end
  end

  // stage 6: entry store read and load write
  logic [DW-1:0] rd_a [NC];
  logic [DW-1:0] rd_b [NC];

  for (genvar j = 0; j < NC; j++) begin : g_copy
    tflm_ram #(.DW(DW)) u_ram (
      .clk_i     (clk_i),
      .en_i      (en),
      .we_i      (s5_q.vld && !s5_q.qry),
      .waddr_i   (idx5_q),
      .wdata_i   (ld5_q),
      .raddr_a_i (ra5_q[j]),
      .raddr_b_i (rb5_q[j]),
      .rdata_a_o (rd_a[j]),
      .rdata_b_o (rd_b[j])
    );
  end

  // stages 7 to 9: lerp along x, y, z per component
  logic signed [FB-1:0] cx   [3][NC];
  logic signed [FB-1:0] cx_q [3][NC];
  logic signed [FB-1:0] cy   [3][2];
  logic signed [FB-1:0] cy_q [3][2];
  logic signed [FB-1:0] cz   [3];
  logic signed [FB-1:0] fld_q [3];
  logic [FRAC_BITS:0]   ty7_q, tz7_q, tz8_q;
  logic                 ok9_q;

  for (genvar c = 0; c < 3; c++) begin : g_comp
    for (genvar j = 0; j < NC; j++) begin : g_x
      tflm_lerp #(.FB(FB), .FRAC(FRAC_BITS)) u_lx (
        .a_i (rd_a[j][c*FB +: FB]),
        .b_i (rd_b[j][c*FB +: FB]),
        .t_i (t6_q[0]),
        .y_o (cx[c][j])
      );
    end
    for (genvar k = 0; k < 2; k++) begin : g_y
      tflm_lerp #(.FB(FB), .FRAC(FRAC_BITS)) u_ly (
        .a_i (cx_q[c][2*k]),
        .b_i (cx_q[c][2*k+1]),
        .t_i (ty7_q),
        .y_o (cy[c][k])
      );
    end
    tflm_lerp #(.FB(FB), .FRAC(FRAC_BITS)) u_lz (
      .a_i (cy_q[c][0]),
      .b_i (cy_q[c][1]),
      .t_i (tz8_q),
      .y_o (cz[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q  <= cx;
      ty7_q <= t6_q[1];
      tz7_q <= t6_q[2];
      ok7_q <= ok6_q;
      cy_q  <= cy;
      tz8_q <= tz7_q;
      ok8_q <= ok7_q;
      for (int c = 0; c < 3; c++) begin
        fld_q[c] <= ok8_q ? cz[c] : '0;
      end
      ok9_q <= ok8_q;
    end
  end

  assign out_valid_o = v9_q;
  assign field_x_o   = fld_q[0];
  assign field_y_o   = fld_q[1];
  assign field_z_o   = fld_q[2];
  assign in_range_o  = ok9_q;

  // checks
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_range_o) |-> (field_x_o == '0 && field_y_o == '0 && field_z_o == '0))
    else $error("outside point with nonzero field");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(field_x_o) && $stable(in_range_o)))
    else $error("stalled item changed");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for trilinear_field_map_lookup_top
// holds a scoreboard class that predicts each query result; depends on tflm_pkg
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_N   = 32;
  localparam int unsigned FB       = 24;
  localparam int unsigned AW       = tflm_pkg::ADDR_W;
  localparam int unsigned PF       = tflm_pkg::POS_FRAC;
  localparam int unsigned DRAIN    = 16;
  localparam logic        CMD_LOAD  = 1'b0;
  localparam logic        CMD_QUERY = 1'b1;

  typedef struct {
    logic                  cmd;
    logic [AW-1:0]         idx;
    logic signed [FB-1:0]  ex, ey, ez;
    logic signed [31:0]    px, py, pz;
  } item_t;

  typedef struct {
    logic signed [FB-1:0] fx, fy, fz;
    logic                 rng;
  } field_t;

  class field_scoreboard;
    longint          origin_q[tflm_pkg::NUM_AXES];
    longint unsigned inv_q[tflm_pkg::NUM_AXES];
    longint          fmem[tflm_pkg::NUM_AXES][tflm_pkg::STORE_DEPTH];
    bit              written[tflm_pkg::STORE_DEPTH];
    field_t          expected_q[$];
    int              errors;

    function new();
      for (int a = 0; a < tflm_pkg::NUM_AXES; a++) begin
        origin_q[a] = 0;
        inv_q[a] = 64'd1 << tflm_pkg::INV_FRAC;
      end
      errors = 0;
    endfunction

    function void report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function void write_reg(logic [2:0] r, logic [31:0] v);
      if (r <= tflm_pkg::REG_ORIGIN_Z) origin_q[r] = longint'(signed'(v));
      else inv_q[r - tflm_pkg::REG_INV_STEP_X] = v;
    endfunction

    function bit map_axis(longint pos, int ax, output int cix, output longint t);
      longint d;
      longint unsigned g, c;
      d = pos - origin_q[ax];
      if (d < 0) begin
        if (inv_q[ax] != 0) return 0;
        g = 0;
      end else begin
        g = (longint'(d) * inv_q[ax]) >> (40 - PF);
      end
      if (g > (longint'(GRID_N - 1) << PF)) return 0;
      c = g >> PF;
      if (c >= GRID_N - 1) c = GRID_N - 2;
      cix = int'(c);
      t = longint'(g - (c << PF));
      return 1;
    endfunction

    function int flat(int i, int j, int k);
      return ((i * GRID_N + j) * GRID_N + k) % tflm_pkg::STORE_DEPTH;
    endfunction

    function longint lerp(longint a, longint b, longint t);
      longint s;
      s = a * ((64'sd1 << PF) - t) + b * t + (64'sd1 << (PF - 1));
      return s >>> PF;
    endfunction

    function bit locate(item_t it, output int c[3], output longint t[3]);
      bit ok;
      ok = map_axis(longint'(it.px), 0, c[0], t[0]);
      ok = map_axis(longint'(it.py), 1, c[1], t[1]) && ok;
      ok = map_axis(longint'(it.pz), 2, c[2], t[2]) && ok;
      return ok;
    endfunction

    function void unwritten_corners(item_t it, ref int miss[$]);
      int c[3];
      longint t[3];
      int f;
      miss.delete();
      if (!locate(it, c, t)) return;
      for (int k = 0; k < 8; k++) begin
        f = flat(c[0] + k[2], c[1] + k[1], c[2] + k[0]);
        if (!written[f]) miss = {miss, f};
      end
    endfunction

    function longint interp(int a, int c[3], longint t[3]);
      longint p00, p10, p01, p11;
      int x, y, z;
      x = c[0];
      y = c[1];
      z = c[2];
      p00 = lerp(fmem[a][flat(x, y, z)], fmem[a][flat(x + 1, y, z)], t[0]);
      p10 = lerp(fmem[a][flat(x, y + 1, z)], fmem[a][flat(x + 1, y + 1, z)], t[0]);
      p01 = lerp(fmem[a][flat(x, y, z + 1)], fmem[a][flat(x + 1, y, z + 1)], t[0]);
      p11 = lerp(fmem[a][flat(x, y + 1, z + 1)], fmem[a][flat(x + 1, y + 1, z + 1)], t[0]);
      return lerp(lerp(p00, p10, t[1]), lerp(p01, p11, t[1]), t[2]);
    endfunction

    function void note_item(item_t it);
      int c[3];
      longint t[3];
      field_t e;
      if (it.cmd == CMD_LOAD) begin
        fmem[0][it.idx] = longint'(it.ex);
        fmem[1][it.idx] = longint'(it.ey);
        fmem[2][it.idx] = longint'(it.ez);
        written[it.idx] = 1;
        return;
      end
      if (locate(it, c, t)) begin
        e.fx = FB'(interp(0, c, t));
        e.fy = FB'(interp(1, c, t));
        e.fz = FB'(interp(2, c, t));
        e.rng = 1;
      end else begin
        e.fx = 0;
        e.fy = 0;
        e.fz = 0;
        e.rng = 0;
      end
      expected_q = {expected_q, e};
    endfunction

    function void check(field_t got);
      field_t e;
      if (expected_q.size() == 0) begin
        report("result with no query pending");
        return;
      end
      e = expected_q.pop_front();
      if (got.fx !== e.fx) report($sformatf("field_x %0d, expected %0d", got.fx, e.fx));
      if (got.fy !== e.fy) report($sformatf("field_y %0d, expected %0d", got.fy, e.fy));
      if (got.fz !== e.fz) report($sformatf("field_z %0d, expected %0d", got.fz, e.fz));
      if (got.rng !== e.rng) report($sformatf("in_range %0b, expected %0b", got.rng, e.rng));
    endfunction

    // points near the low and high grid ends so corner entries get reused, random for zero inverse step
    function logic [31:0] target_pos(int ax);
      longint unsigned g, d;
      bit lo;
      lo = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: g = 0;
        1: g = longint'(GRID_N - 1) << PF;
        2: g = longint'(lo ? $urandom_range(0, 1) : $urandom_range(GRID_N - 3, GRID_N - 1)) << PF;
        default: g = lo ? $urandom_range(0, (2 << PF) - 1)
                        : $urandom_range((GRID_N - 3) << PF, (GRID_N - 1) << PF);
      endcase
      if (inv_q[ax] == 0) return $urandom;
      d = ((g << (40 - PF)) + inv_q[ax] - 1) / inv_q[ax];
      if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      return 32'(longint'(origin_q[ax]) + longint'(d));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i = CMD_LOAD;
  logic [AW-1:0]        entry_index_i = '0;
  logic signed [FB-1:0] load_ex_i = '0, load_ey_i = '0, load_ez_i = '0;
  logic signed [31:0]   pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [FB-1:0] field_x_o, field_y_o, field_z_o;
  logic                 in_range_o;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tflm_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  field_scoreboard sb;
  bit              no_idle = 0;
  int              rx_hold = 0;
  int              rx_wait = 0;

  trilinear_field_map_lookup_top DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_stall_i = 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_stall_i = 1'b1;
        rx_wait--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    field_t got;
    if (out_valid_o && !out_stall_i) begin
      got.fx = field_x_o;
      got.fy = field_y_o;
      got.fz = field_z_o;
      got.rng = in_range_o;
      sb.check(got);
      rx_wait = no_idle ? 0 : $urandom_range(0, 4);
    end
  end

  task automatic send(item_t it);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i = it.cmd;
    entry_index_i = it.idx;
    load_ex_i = it.ex;
    load_ey_i = it.ey;
    load_ez_i = it.ez;
    pos_x_i = it.px;
    pos_y_i = it.py;
    pos_z_i = it.pz;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_load(int idx, int ex, int ey, int ez);
    item_t it;
    it.cmd = CMD_LOAD;
    it.idx = AW'(idx);
    it.ex = FB'(ex);
    it.ey = FB'(ey);
    it.ez = FB'(ez);
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    send(it);
  endtask

  task automatic send_query(logic [31:0] px, py, pz);
    item_t it;
    int miss[$];
    it.cmd = CMD_QUERY;
    it.idx = AW'($urandom);
    it.ex = FB'($urandom);
    it.ey = FB'($urandom);
    it.ez = FB'($urandom);
    it.px = px;
    it.py = py;
    it.pz = pz;
    sb.unwritten_corners(it, miss);
    foreach (miss[i]) send_load(miss[i], $urandom, $urandom, $urandom);
    send(it);
  endtask

  task automatic reg_write(logic [2:0] r, logic [31:0] v);
    logic [31:0] got;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== v) sb.report($sformatf("register %0d reads %h, wrote %h", r, got, v));
    sb.write_reg(r, v);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= 40 && n < 70);
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        send_load($urandom_range(0, tflm_pkg::STORE_DEPTH - 1), $urandom, $urandom, $urandom);
      end else if (kind < 8) begin
        send_query(sb.target_pos(0), sb.target_pos(1), sb.target_pos(2));
      end else begin
        send_query($urandom, $urandom, $urandom);
      end
    end
    no_idle = 0;
  endtask

  initial begin
    logic [31:0] top;
    sb = new();
    top = (GRID_N - 1) << PF;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // cell zero corners at the field extremes, then edge, rounding and out-of-range points
    for (int k = 0; k < 8; k++)
      send_load(sb.flat(k[2], k[1], k[0]), k[0] ? 24'sh7FFFFF : 24'sh800000,
                k[1] ? 24'sh7FFFFF : 24'sh800000, k[2] ? 24'sh800000 : 24'sh7FFFFF);
    send_query(0, 0, 0);
    send_query(32'h8000, 32'h8000, 32'h8000);
    send_query(32'h4000, 32'hC000, 32'h8000);
    send_query(top, top, top);
    send_query(top - 1, top, 32'h8000);
    send_query(top + 1, 0, 0);
    send_query(0, 32'hFFFF_FFFF, 0);
    send_query(0, 0, top + 32'h10000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_items(100);
    drain();

    reg_write(tflm_pkg::REG_ORIGIN_X, -(5 << PF) + $urandom_range(0, 65535));
    reg_write(tflm_pkg::REG_ORIGIN_Y, $urandom_range(0, 1 << 20));
    reg_write(tflm_pkg::REG_ORIGIN_Z, -$urandom_range(0, 1 << 24));
    reg_write(tflm_pkg::REG_INV_STEP_X, 32'h0200_0000);
    reg_write(tflm_pkg::REG_INV_STEP_Y, 32'h0080_0000);
    reg_write(tflm_pkg::REG_INV_STEP_Z, $urandom_range(32'h0010_0000, 32'h0400_0000));
    random_items(100);
    drain();

    reg_write(tflm_pkg::REG_ORIGIN_X, 32'h8000_0000);
    reg_write(tflm_pkg::REG_ORIGIN_Y, 32'h7FFF_FFFF);
    reg_write(tflm_pkg::REG_ORIGIN_Z, 32'h0000_0000);
    reg_write(tflm_pkg::REG_INV_STEP_X, 32'hFFFF_FFFF);
    reg_write(tflm_pkg::REG_INV_STEP_Y, 32'h0000_0000);
    reg_write(tflm_pkg::REG_INV_STEP_Z, 32'h0000_0001);
    send_query(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    random_items(100);
    drain();

    for (int r = tflm_pkg::REG_ORIGIN_X; r <= tflm_pkg::REG_ORIGIN_Z; r++)
      reg_write(3'(r), $urandom);
    for (int r = tflm_pkg::REG_INV_STEP_X; r <= tflm_pkg::REG_INV_STEP_Z; r++)
      reg_write(3'(r), $urandom);
    random_items(100);
    drain();

    for (int r = tflm_pkg::REG_ORIGIN_X; r <= tflm_pkg::REG_ORIGIN_Z; r++)
      reg_write(3'(r), 32'h0);
    for (int r = tflm_pkg::REG_INV_STEP_X; r <= tflm_pkg::REG_INV_STEP_Z; r++)
      reg_write(3'(r), 32'h0100_0000);
    // receiver holds off while items keep coming so the pipeline backs up
    rx_hold = 200;
    no_idle = 1;
    for (int n = 0; n < 40; n++) send_query(sb.target_pos(0), sb.target_pos(1), sb.target_pos(2));
    no_idle = 0;
    random_items(100);
    drain();

    if (sb.expected_q.size() != 0) sb.report("queries left without result");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
